// ----- rtl/tsms_pkg.sv -----
package tsms_pkg;

    // table geometry
    localparam int SONG_DEPTH  = 256;
    localparam int SONG_AW     = $clog2(SONG_DEPTH);
    localparam int TABLE_DEPTH = 2 * SONG_DEPTH;
    localparam int TABLE_AW    = SONG_AW + 1;
    // wide enough for a song length and for position + 1
    localparam int LEN_W       = (SONG_AW + 1 > 9) ? SONG_AW + 1 : 9;

    // field widths
    localparam int FREQ_W = 16;
    localparam int DIV_W  = 8;
    localparam int TICK_W = 16;
    localparam int PCT_W  = 8;
    localparam int CFG_W  = 16;
    localparam int ENTRY_W = FREQ_W + DIV_W;

    // note length when the divisor is zero
    localparam logic [TICK_W-1:0] DEFAULT_NOTE_TICKS = TICK_W'(100);

    // pause = note_length * percent / 100, done as multiply by reciprocal
    localparam int PROD_W      = TICK_W + PCT_W;
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] PAUSE_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
    localparam int SCALED_W    = PROD_W + RECIP_W;
    localparam int QUOT_W      = SCALED_W - RECIP_SHIFT;

    // restoring divider steps, one per numerator bit
    localparam int DIV_STEPS = TICK_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // function codes of an input item
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_CTRL = 2'd1;
    localparam logic [1:0] FUNC_LOAD = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TEMPO_NUM  = 2'd0;
    localparam logic [1:0] REG_PAUSE_PCT  = 2'd1;
    localparam logic [1:0] REG_NORMAL_LEN = 2'd2;
    localparam logic [1:0] REG_ALARM_LEN  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_NOTE  = 2'd1,
        PH_PAUSE = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SETUP,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_NOTE,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic        sound_enable;
        logic        alarm_request;
        logic        load_song;
        logic [7:0]  load_index;
        logic [15:0] load_frequency;
        logic [7:0]  load_divisor;
    } item_t;

    typedef struct packed {
        logic [15:0] tone_frequency;
        logic        playing;
        logic        alarm_song_selected;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic setup;
        logic div_step;
        logic mul1;
        logic mul2;
        logic note;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_note;
        logic div_zero;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/tsms_ram.sv -----
module tsms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tsms_datapath.sv -----
module tsms_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsms_pkg::item_t       item,
    input  tsms_pkg::dp_cmd_t     cmd,
    output tsms_pkg::dp_status_t  status,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    output tsms_pkg::result_t     result,
    output logic                  result_valid,
    input  logic                  result_ready
);

    import tsms_pkg::*;

    // configuration
    logic [TICK_W-1:0] tempo_num_reg;
    logic [PCT_W-1:0]  pause_pct_reg;
    logic [8:0]        normal_len_reg;
    logic [8:0]        alarm_len_reg;

    // player state
    logic [SONG_AW-1:0] pos_reg, pos_next;
    phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next;
    logic [TICK_W-1:0]  note_len_reg, note_len_next;
    logic [TICK_W-1:0]  pause_len_reg, pause_len_next;
    logic               active_reg, active_next;
    logic               alarm_reg, alarm_next;
    logic [FREQ_W-1:0]  tone_reg, tone_next;

    // working registers
    item_t              item_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [DIV_W-1:0]   divisor_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [TICK_W-1:0]  quo_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SCALED_W-1:0] scaled_reg;

    // output stage
    result_t            result_reg;
    logic               result_valid_reg;

    // table memory
    logic                ram_we;
    logic [TABLE_AW-1:0] ram_waddr;
    logic [TABLE_AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [FREQ_W-1:0]   rd_freq;
    logic [DIV_W-1:0]    rd_div;

    // misc combinational
    logic [TICK_W-1:0]  elapsed_inc;
    logic [8:0]         cur_len;
    logic [LEN_W-1:0]   len_ext;
    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   pos_plus;
    logic [SONG_AW-1:0] pos_adv;
    logic [DIV_W:0]     div_shift;
    logic [DIV_W:0]     div_trial;
    logic               div_bit;
    logic [DIV_W-1:0]   rem_step;
    logic [TICK_W-1:0]  quo_step;
    logic [QUOT_W-1:0]  pause_quot;
    logic               pause_end;

    tsms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({item_reg.load_frequency, item_reg.load_divisor}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // table write on a load beat, read always at the current entry
    assign ram_we    = cmd.exec && (item_reg.func == FUNC_LOAD)
                       && (32'(item_reg.load_index) < SONG_DEPTH);
    assign ram_waddr = {item_reg.load_song, SONG_AW'(item_reg.load_index)};
    assign ram_raddr = {alarm_reg, pos_reg};
    assign rd_freq   = ram_rdata[ENTRY_W-1:DIV_W];
    assign rd_div    = ram_rdata[DIV_W-1:0];

    // saturating tick count
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    // effective song length and wrapped next position
    assign cur_len  = alarm_reg ? alarm_len_reg : normal_len_reg;
    assign len_ext  = LEN_W'(cur_len);
    always_comb
    begin
        if (len_ext == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_ext > LEN_W'(SONG_DEPTH))
        begin
            eff_len = LEN_W'(SONG_DEPTH);
        end
        else
        begin
            eff_len = len_ext;
        end
    end
    assign pos_plus = LEN_W'(pos_reg) + 1'b1;
    assign pos_adv  = (pos_plus >= eff_len) ? '0 : SONG_AW'(pos_plus);

    assign pause_end = (phase_reg == PH_PAUSE) && (elapsed_inc >= pause_len_reg);

    // one restoring divider step
    assign div_shift = {rem_reg, quo_reg[TICK_W-1]};
    assign div_trial = div_shift - {1'b0, divisor_reg};
    assign div_bit   = (div_shift >= {1'b0, divisor_reg});
    assign rem_step  = div_bit ? div_trial[DIV_W-1:0] : div_shift[DIV_W-1:0];
    assign quo_step  = {quo_reg[TICK_W-2:0], div_bit};

    // scaled product shifted back to ticks, saturated at note start
    assign pause_quot = scaled_reg[SCALED_W-1:RECIP_SHIFT];

    // status to the controller
    assign status.start_note = (item_reg.func == FUNC_TICK) && active_reg
                               && ((phase_reg == PH_IDLE) || pause_end);
    assign status.div_zero   = (rd_div == '0);
    assign status.div_last   = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign status.out_free   = !result_valid_reg || result_ready;

    // next player state
    always_comb
    begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        note_len_next  = note_len_reg;
        pause_len_next = pause_len_reg;
        active_next    = active_reg;
        alarm_next     = alarm_reg;
        tone_next      = tone_reg;

        if (cmd.exec)
        begin
            case (item_reg.func)
                FUNC_TICK:
                begin
                    if (active_reg && (phase_reg != PH_IDLE))
                    begin
                        if (phase_reg == PH_NOTE)
                        begin
                            if (elapsed_inc < note_len_reg)
                            begin
                                elapsed_next = elapsed_inc;
                            end
                            else
                            begin
                                tone_next    = '0;
                                phase_next   = PH_PAUSE;
                                elapsed_next = '0;
                            end
                        end
                        else if (!pause_end)
                        begin
                            elapsed_next = elapsed_inc;
                        end
                        else
                        begin
                            pos_next = pos_adv;
                        end
                    end
                end
                FUNC_CTRL:
                begin
                    if (!(item_reg.sound_enable || item_reg.alarm_request))
                    begin
                        pos_next     = '0;
                        phase_next   = PH_IDLE;
                        elapsed_next = '0;
                        tone_next    = '0;
                        active_next  = 1'b0;
                    end
                    else if (!active_reg || (item_reg.alarm_request != alarm_reg))
                    begin
                        alarm_next   = item_reg.alarm_request;
                        pos_next     = '0;
                        phase_next   = PH_IDLE;
                        elapsed_next = '0;
                        active_next  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // note length from the default or from the divider
        if (cmd.setup && status.div_zero)
        begin
            note_len_next = DEFAULT_NOTE_TICKS;
        end
        if (cmd.div_step && status.div_last)
        begin
            note_len_next = quo_step;
        end

        // note start
        if (cmd.note)
        begin
            pause_len_next = (pause_quot > QUOT_W'(16'hFFFF)) ? '1 : TICK_W'(pause_quot);
            tone_next      = freq_reg;
            phase_next     = PH_NOTE;
            elapsed_next   = '0;
        end
    end

    // player state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= PH_IDLE;
            elapsed_reg    <= '0;
            note_len_reg   <= '0;
            pause_len_reg  <= '0;
            active_reg     <= 1'b0;
            alarm_reg      <= 1'b0;
            tone_reg       <= '0;
            tempo_num_reg  <= TICK_W'(1000);
            pause_pct_reg  <= PCT_W'(30);
            normal_len_reg <= 9'd1;
            alarm_len_reg  <= 9'd1;
        end
        else
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            note_len_reg  <= note_len_next;
            pause_len_reg <= pause_len_next;
            active_reg    <= active_next;
            alarm_reg     <= alarm_next;
            tone_reg      <= tone_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TEMPO_NUM:  tempo_num_reg  <= cfg_wdata[TICK_W-1:0];
                    REG_PAUSE_PCT:  pause_pct_reg  <= cfg_wdata[PCT_W-1:0];
                    REG_NORMAL_LEN: normal_len_reg <= cfg_wdata[8:0];
                    REG_ALARM_LEN:  alarm_len_reg  <= cfg_wdata[8:0];
                endcase
            end
        end
    end

    // item capture, divider and multiplier registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        if (cmd.setup)
        begin
            freq_reg    <= rd_freq;
            divisor_reg <= rd_div;
            rem_reg     <= '0;
            quo_reg     <= tempo_num_reg;
            dcnt_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_step;
            quo_reg  <= quo_step;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.mul1)
        begin
            prod_reg <= note_len_reg * pause_pct_reg;
        end
        if (cmd.mul2)
        begin
            scaled_reg <= prod_reg * PAUSE_RECIP;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.tone_frequency      <= tone_reg;
            result_reg.playing             <= active_reg;
            result_reg.alarm_song_selected <= alarm_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ----- rtl/tsms_ctrl.sv -----
module tsms_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  tsms_pkg::dp_status_t status,
    output tsms_pkg::dp_cmd_t    cmd
);

    import tsms_pkg::*;

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (item_valid) state_next = S_EXEC;
            S_EXEC:  state_next = status.start_note ? S_READ : S_OUT;
            S_READ:  state_next = S_SETUP;
            S_SETUP: state_next = status.div_zero ? S_MUL1 : S_DIV;
            S_DIV:   if (status.div_last) state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_NOTE;
            S_NOTE:  state_next = S_OUT;
            S_OUT:   if (status.out_free) state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                cmd.accept = item_valid;
            end
            S_EXEC:  cmd.exec     = 1'b1;
            S_READ:  ;
            S_SETUP: cmd.setup    = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_MUL1:  cmd.mul1     = 1'b1;
            S_MUL2:  cmd.mul2     = 1'b1;
            S_NOTE:  cmd.note     = 1'b1;
            S_OUT:   cmd.load_out = status.out_free;
        endcase
    end

endmodule

// ----- rtl/two_song_melody_sequencer_core.sv -----
// Looping two-song melody player.
// Input beats on item/item_valid/item_ready carry a 1 ms tick, a control
// update (enable, alarm request) or a note table load. Every input beat
// gives exactly one result beat on result/result_valid/result_ready with the
// current tone frequency, the playing flag and the selected song.
// Configuration (tempo numerator, pause percent, both song lengths) is
// written through cfg_we/cfg_index/cfg_wdata with no handshake; the user
// must write it only while idle, and the block itself does not enforce it.
// A load, a control update or a tick that starts no note passes through
// the exec and output states. A tick that starts a note also reads the
// table, sets up, runs the 16-step restoring divider for the note length
// when the divisor is nonzero, does the two registered multiplies for the
// pause and starts the note before the output state. One item is worked on
// at a time; the next is taken in the idle state after the result is loaded.
// A result waits in an output register; the next item is accepted and
// worked on meanwhile and its result waits until that register is free.
// Reset clears the player (idle, position 0, silent, normal song) and
// loads default configuration; note tables are not cleared and must be
// loaded before use.
module two_song_melody_sequencer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  tsms_pkg::item_t     item,
    input  logic                item_valid,
    output logic                item_ready,
    output tsms_pkg::result_t   result,
    output logic                result_valid,
    input  logic                result_ready,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);

    import tsms_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tsms_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    tsms_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule
